>>> rtl/line_intersection_point_unit_macros.svh
// Assertion macros for the line intersection block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef LINE_INTERSECTION_POINT_UNIT_MACROS_SVH
`define LINE_INTERSECTION_POINT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define LIPU_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// Next-cycle implication.
`define LIPU_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define LIPU_ASSERT_IMP(lbl, a, b, msg)
`define LIPU_ASSERT_NXT(lbl, a, b, msg)
`endif
`endif

>>> rtl/lipu_pkg.sv
package lipu_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_BITS   = 48;
  localparam int FIELD_BITS = 16;

  localparam int D_W  = COORD_BITS + 1;          // coordinate difference
  localparam int P_W  = 2 * D_W;                 // cross product term
  localparam int X_W  = P_W + 1;                 // den / num
  localparam int M_W  = D_W + X_W;               // |d| * |num|
  localparam int DV_W = M_W + FRAC_BITS;         // scaled dividend
  localparam int Q_W  = OUT_BITS + 1;            // quotient bits kept
  localparam int DP_W = (DV_W > Q_W) ? DV_W : Q_W + 1;
  localparam int T_W  = DP_W - Q_W;              // dividend bits above quotient range
  localparam int C_W  = (T_W > X_W) ? T_W : X_W;
  localparam int B_W  = COORD_BITS + FRAC_BITS;
  localparam int S_W  = ((Q_W > B_W) ? Q_W : B_W) + 2;
  localparam int FRONT_STAGES = 5;
  localparam int NUM_STAGES   = FRONT_STAGES + Q_W + 1;

  typedef struct packed {
    logic [X_W-1:0] rem;
    logic [Q_W-1:0] lo;
    logic [Q_W-1:0] q;
  } lipu_lane_t;

  typedef struct packed {
    lipu_lane_t                   lx;
    lipu_lane_t                   ly;
    logic [X_W-1:0]               mden;
    logic                         neg_x;
    logic                         neg_y;
    logic                         ovq_x;
    logic                         ovq_y;
    logic                         par;
    logic signed [COORD_BITS-1:0] base_x;
    logic signed [COORD_BITS-1:0] base_y;
  } lipu_div_t;

  function automatic logic [D_W-1:0] mag_d(input logic signed [D_W-1:0] v);
    mag_d = v[D_W-1] ? D_W'(-v) : D_W'(v);
  endfunction

  function automatic logic [X_W-1:0] mag_x(input logic signed [X_W-1:0] v);
    mag_x = v[X_W-1] ? X_W'(-v) : X_W'(v);
  endfunction
endpackage

>>> rtl/lipu_div_step.sv
module lipu_div_step import lipu_pkg::*; (
  input  lipu_lane_t     lane_i,
  input  logic [X_W-1:0] mden,
  output lipu_lane_t     lane_o
);
  logic [X_W:0] rs;
  logic [X_W:0] diff;
  logic         ge;

  // restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    rs   = {lane_i.rem, lane_i.lo[Q_W-1]};
    ge   = rs >= {1'b0, mden};
    diff = rs - {1'b0, mden};
    lane_o.rem = ge ? diff[X_W-1:0] : rs[X_W-1:0];
    lane_o.q   = {lane_i.q[Q_W-2:0], ge};
    lane_o.lo  = {lane_i.lo[Q_W-2:0], 1'b0};
  end
endmodule

>>> rtl/line_intersection_point_unit.sv
// Channel | Ports                          | Beat contents
// in      | in_tvalid/in_tready/in_tdata   | four points, 8 x 16-bit signed coordinates
// out     | out_tvalid/out_tready/out_tdata| cross_x, cross_y (48-bit, 16 frac bits)
//         | out_tuser                      | is_parallel, overflowed
//
// One beat per cycle sustained while out_tready stays high; five arithmetic stages
// feed the 49-stage one-bit-per-stage restoring divider, then the output register.
// Reset (rst_n low, synchronous) clears all stage valid bits; data regs are not reset.
// Stalls: a stage holds only when it is full and the stage after it holds, so
// bubbles are squeezed out and input is taken while a result waits, if any stage is empty.
`include "line_intersection_point_unit_macros.svh"
module line_intersection_point_unit import lipu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // cross_x [47:0], cross_y [95:48]
  output logic [95:0]  out_tdata,
  // is_parallel [0], overflowed [1]
  output logic [1:0]   out_tuser
);
  localparam int LAST = NUM_STAGES - 1;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] hold;
  logic [NUM_STAGES-1:0] en;

  // hold ripples back from the output register
  always_comb begin
    hold[LAST] = v_r[LAST] & ~out_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      hold[k] = v_r[k] & hold[k+1];
    end
    en = ~hold;
  end

  assign in_tready = ~hold[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= (k == 0) ? in_tvalid : v_r[k-1];
        end
      end
    end
  end

  // stage 1: unpack, differences
  logic signed [COORD_BITS-1:0] pt [8];
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      pt[i] = signed'(in_tdata[i*FIELD_BITS +: COORD_BITS]);
    end
  end

  logic signed [COORD_BITS-1:0] s1_ax_r, s1_ay_r;
  logic signed [D_W-1:0]        s1_dx_r, s1_dy_r, s1_fx_r, s1_fy_r, s1_gx_r, s1_gy_r;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_ax_r <= pt[0];
      s1_ay_r <= pt[1];
      s1_dx_r <= D_W'(pt[2]) - D_W'(pt[0]);
      s1_dy_r <= D_W'(pt[3]) - D_W'(pt[1]);
      s1_fx_r <= D_W'(pt[6]) - D_W'(pt[4]);
      s1_fy_r <= D_W'(pt[7]) - D_W'(pt[5]);
      s1_gx_r <= D_W'(pt[0]) - D_W'(pt[4]);
      s1_gy_r <= D_W'(pt[1]) - D_W'(pt[5]);
    end
  end

  // stage 2: cross product terms
  logic signed [COORD_BITS-1:0] s2_ax_r, s2_ay_r;
  logic signed [D_W-1:0]        s2_dx_r, s2_dy_r;
  logic signed [P_W-1:0]        s2_dfy_r, s2_dyf_r, s2_gfy_r, s2_gyf_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_ax_r  <= s1_ax_r;
      s2_ay_r  <= s1_ay_r;
      s2_dx_r  <= s1_dx_r;
      s2_dy_r  <= s1_dy_r;
      s2_dfy_r <= s1_dx_r * s1_fy_r;
      s2_dyf_r <= s1_dy_r * s1_fx_r;
      s2_gfy_r <= s1_gx_r * s1_fy_r;
      s2_gyf_r <= s1_gy_r * s1_fx_r;
    end
  end

  // stage 3: den and num
  logic signed [COORD_BITS-1:0] s3_ax_r, s3_ay_r;
  logic signed [D_W-1:0]        s3_dx_r, s3_dy_r;
  logic signed [X_W-1:0]        s3_den_r, s3_num_r;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_ax_r  <= s2_ax_r;
      s3_ay_r  <= s2_ay_r;
      s3_dx_r  <= s2_dx_r;
      s3_dy_r  <= s2_dy_r;
      s3_den_r <= X_W'(s2_dfy_r) - X_W'(s2_dyf_r);
      s3_num_r <= X_W'(s2_gyf_r) - X_W'(s2_gfy_r);
    end
  end

  // stage 4: magnitudes, signs, |d|*|num|
  logic signed [COORD_BITS-1:0] s4_ax_r, s4_ay_r;
  logic [M_W-1:0]               s4_mx_r, s4_my_r;
  logic [X_W-1:0]               s4_mden_r;
  logic                         s4_neg_x_r, s4_neg_y_r, s4_par_r;
  logic                         sgn_nd;
  assign sgn_nd = s3_num_r[X_W-1] ^ s3_den_r[X_W-1];
  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_ax_r    <= s3_ax_r;
      s4_ay_r    <= s3_ay_r;
      s4_mx_r    <= M_W'(mag_d(s3_dx_r)) * M_W'(mag_x(s3_num_r));
      s4_my_r    <= M_W'(mag_d(s3_dy_r)) * M_W'(mag_x(s3_num_r));
      s4_mden_r  <= mag_x(s3_den_r);
      s4_neg_x_r <= s3_dx_r[D_W-1] ^ sgn_nd;
      s4_neg_y_r <= s3_dy_r[D_W-1] ^ sgn_nd;
      s4_par_r   <= s3_den_r == '0;
    end
  end

  // stage 5: scale dividend, detect quotient beyond kept range, seed divider
  logic [DP_W-1:0] dvx, dvy;
  logic [T_W-1:0]  topx, topy;
  logic            ovx, ovy;
  lipu_div_t       dv_r [Q_W+1];
  lipu_div_t       dv_nxt [Q_W];

  always_comb begin
    dvx  = DP_W'(s4_mx_r) << FRAC_BITS;
    dvy  = DP_W'(s4_my_r) << FRAC_BITS;
    topx = dvx[DP_W-1:Q_W];
    topy = dvy[DP_W-1:Q_W];
    ovx  = C_W'(topx) >= C_W'(s4_mden_r);
    ovy  = C_W'(topy) >= C_W'(s4_mden_r);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      dv_r[0].lx.rem <= ovx ? '0 : X_W'(C_W'(topx));
      dv_r[0].lx.lo  <= dvx[Q_W-1:0];
      dv_r[0].lx.q   <= '0;
      dv_r[0].ly.rem <= ovy ? '0 : X_W'(C_W'(topy));
      dv_r[0].ly.lo  <= dvy[Q_W-1:0];
      dv_r[0].ly.q   <= '0;
      dv_r[0].mden   <= s4_mden_r;
      dv_r[0].neg_x  <= s4_neg_x_r;
      dv_r[0].neg_y  <= s4_neg_y_r;
      dv_r[0].ovq_x  <= ovx;
      dv_r[0].ovq_y  <= ovy;
      dv_r[0].par    <= s4_par_r;
      dv_r[0].base_x <= s4_ax_r;
      dv_r[0].base_y <= s4_ay_r;
    end
  end

  // divider pipeline, one quotient bit per stage
  for (genvar i = 0; i < Q_W; i++) begin : g_div
    lipu_div_step u_step_x (.lane_i(dv_r[i].lx), .mden(dv_r[i].mden), .lane_o(dv_nxt[i].lx));
    lipu_div_step u_step_y (.lane_i(dv_r[i].ly), .mden(dv_r[i].mden), .lane_o(dv_nxt[i].ly));
    assign dv_nxt[i].mden   = dv_r[i].mden;
    assign dv_nxt[i].neg_x  = dv_r[i].neg_x;
    assign dv_nxt[i].neg_y  = dv_r[i].neg_y;
    assign dv_nxt[i].ovq_x  = dv_r[i].ovq_x;
    assign dv_nxt[i].ovq_y  = dv_r[i].ovq_y;
    assign dv_nxt[i].par    = dv_r[i].par;
    assign dv_nxt[i].base_x = dv_r[i].base_x;
    assign dv_nxt[i].base_y = dv_r[i].base_y;

    always_ff @(posedge clk) begin
      if (en[FRONT_STAGES + i]) begin
        dv_r[i+1] <= dv_nxt[i];
      end
    end
  end

  // final stage: sign, add base, saturate
  localparam logic signed [S_W-1:0] TOP = (S_W'(1) <<< (OUT_BITS - 1)) - S_W'(1);
  localparam logic signed [S_W-1:0] BOT = -TOP - S_W'(1);

  lipu_div_t fin;
  assign fin = dv_r[Q_W];

  logic signed [S_W-1:0] qx, qy, sx, sy;
  logic                  satx, saty;
  logic [OUT_BITS-1:0]   rx, ry;

  always_comb begin
    qx = fin.neg_x ? -S_W'(fin.lx.q) : S_W'(fin.lx.q);
    qy = fin.neg_y ? -S_W'(fin.ly.q) : S_W'(fin.ly.q);
    sx = (S_W'(fin.base_x) <<< FRAC_BITS) + qx;
    sy = (S_W'(fin.base_y) <<< FRAC_BITS) + qy;
    satx = fin.ovq_x || sx > TOP || sx < BOT;
    saty = fin.ovq_y || sy > TOP || sy < BOT;
    if (fin.ovq_x) begin
      rx = fin.neg_x ? BOT[OUT_BITS-1:0] : TOP[OUT_BITS-1:0];
    end else if (sx > TOP) begin
      rx = TOP[OUT_BITS-1:0];
    end else if (sx < BOT) begin
      rx = BOT[OUT_BITS-1:0];
    end else begin
      rx = sx[OUT_BITS-1:0];
    end
    if (fin.ovq_y) begin
      ry = fin.neg_y ? BOT[OUT_BITS-1:0] : TOP[OUT_BITS-1:0];
    end else if (sy > TOP) begin
      ry = TOP[OUT_BITS-1:0];
    end else if (sy < BOT) begin
      ry = BOT[OUT_BITS-1:0];
    end else begin
      ry = sy[OUT_BITS-1:0];
    end
  end

  logic [OUT_BITS-1:0] out_x_r, out_y_r;
  logic                out_par_r, out_ovf_r;
  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      out_x_r   <= fin.par ? '0 : rx;
      out_y_r   <= fin.par ? '0 : ry;
      out_par_r <= fin.par;
      out_ovf_r <= ~fin.par & (satx | saty);
    end
  end

  assign out_tvalid = v_r[LAST];
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = {out_ovf_r, out_par_r};

  `LIPU_ASSERT_IMP(a_par_clean, out_tvalid && out_tuser[0], out_tdata == '0 && !out_tuser[1], "parallel result not clean")
  `LIPU_ASSERT_IMP(a_ovf_sat, out_tvalid && out_tuser[1], out_x_r == TOP[OUT_BITS-1:0] || out_x_r == BOT[OUT_BITS-1:0] || out_y_r == TOP[OUT_BITS-1:0] || out_y_r == BOT[OUT_BITS-1:0], "overflow without saturated coordinate")
  `LIPU_ASSERT_IMP(a_stall_src, !in_tready, out_tvalid && !out_tready, "input stalled without output backpressure")
  `LIPU_ASSERT_NXT(a_accept_lands, in_tvalid && in_tready, v_r[0], "accepted beat lost at first stage")
endmodule

>>> tb/line_intersection_point_unit_tb.sv
module line_intersection_point_unit_tb import lipu_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected content of one out beat.
  typedef struct {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic                       par;
    logic                       ovf;
  } meet_point_t;

  localparam int WATCHDOG_LIMIT = 20000;  // beatless cycles before giving up
  localparam int RX_HOLD_CYCLES = 400;    // long receiver back-pressure stretch
  localparam int DRAIN_CYCLES   = 80;     // > NUM_STAGES

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // a_start_x..b_end_y, 16 bits each, a_start_x lowest
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;      // cross_x [47:0], cross_y [95:48]
  logic [1:0]   out_tuser;      // is_parallel [0], overflowed [1]

  always #5 clk = ~clk;

  line_intersection_point_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  logic [127:0] pend_pts[$];       // line pairs waiting to be driven
  meet_point_t  meet_expected[$];  // predicted points in beat order
  int  n_queued = 0, n_in = 0, n_out = 0, n_mismatch = 0;
  int  n_par = 0, n_ovf = 0;
  bit  no_idle = 0, rx_hold_req = 0;
  bit  in_taken = 0;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  // Coordinate field -> signed value; only the low COORD_BITS count.
  function automatic logic signed [127:0] coord_val(input logic [15:0] raw);
    logic signed [COORD_BITS-1:0] c;
    c = raw[COORD_BITS-1:0];
    return c;
  endfunction

  // base + d*num*2^FRAC/den, quotient truncated toward zero and capped at
  // 2^62, then clamped to the signed OUT_BITS range.
  function automatic logic signed [OUT_BITS-1:0] fix_coord(
      input logic signed [127:0] base, d, num, den, inout logic ovf);
    logic [127:0] md, mn, mden, q;
    logic signed [127:0] sq, sum, top, bot;
    logic neg;
    md   = d   < 0 ? -d   : d;
    mn   = num < 0 ? -num : num;
    mden = den < 0 ? -den : den;
    neg  = ((d < 0) != (num < 0)) != (den < 0);
    q    = ((md * mn) << FRAC_BITS) / mden;
    if (q > (128'd1 << 62)) q = 128'd1 << 62;
    sq   = neg ? -$signed(q) : $signed(q);
    sum  = (base <<< FRAC_BITS) + sq;
    top  = (128'sd1 <<< (OUT_BITS - 1)) - 1;
    bot  = -top - 1;
    if (sum > top) begin sum = top; ovf = 1'b1; end
    if (sum < bot) begin sum = bot; ovf = 1'b1; end
    return sum[OUT_BITS-1:0];
  endfunction

  function automatic meet_point_t predict_meet(input logic [127:0] pts);
    logic signed [127:0] ax, ay, bx, by, cx, cy, ex, ey;
    logic signed [127:0] dx, dy, fx, fy, gx, gy, den, num;
    meet_point_t r;
    ax = coord_val(pts[15:0]);    ay = coord_val(pts[31:16]);
    bx = coord_val(pts[47:32]);   by = coord_val(pts[63:48]);
    cx = coord_val(pts[79:64]);   cy = coord_val(pts[95:80]);
    ex = coord_val(pts[111:96]);  ey = coord_val(pts[127:112]);
    dx = bx - ax;  dy = by - ay;
    fx = ex - cx;  fy = ey - cy;
    gx = ax - cx;  gy = ay - cy;
    den = dx * fy - dy * fx;
    num = -(gx * fy - gy * fx);
    r = '{x: '0, y: '0, par: 1'b0, ovf: 1'b0};
    if (den == 0) begin
      r.par = 1'b1;   // parallel or coincident: zero point, no overflow
      return r;
    end
    r.x = fix_coord(ax, dx, num, den, r.ovf);
    r.y = fix_coord(ay, dy, num, den, r.ovf);
    return r;
  endfunction

  function automatic logic [127:0] pack_pts(input int ax, ay, bx, by, cx, cy, ex, ey);
    logic [15:0] v[8];
    v = '{ax[15:0], ay[15:0], bx[15:0], by[15:0], cx[15:0], cy[15:0], ex[15:0], ey[15:0]};
    return {v[7], v[6], v[5], v[4], v[3], v[2], v[1], v[0]};
  endfunction

  task automatic queue_pts(input logic [127:0] pts);
    pend_pts.push_back(pts);
    n_queued++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: new beat offered at the falling edge, random idle bursts
  // ---------------------------------------------------------------------
  int tx_gap = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // beat still offered, keep it stable
    end else if (tx_gap > 0) begin
      tx_gap--;
      in_tvalid <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 11) == 0) begin
      tx_gap = $urandom_range(1, 17) - 1;
      in_tvalid <= 1'b0;
    end else if (pend_pts.size() > 0) begin
      in_tdata  <= pend_pts.pop_front();
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts plus one long hold-off to fill the pipe
  // ---------------------------------------------------------------------
  int  rx_gap = 0, rx_hold = 0;
  bit  rx_hold_done = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_req && !rx_hold_done) begin
      rx_hold_done = 1;
      rx_hold = RX_HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 11) == 0) begin
      rx_gap = $urandom_range(1, 17) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor and scoreboard, sampled at the rising edge
  // ---------------------------------------------------------------------
  int idle_cycles = 0;
  always @(posedge clk) begin
    meet_point_t e;
    logic signed [OUT_BITS-1:0] got_x, got_y;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      e = predict_meet(in_tdata);
      meet_expected.push_back(e);
      n_in++;
      if (e.par) n_par++;
      if (e.ovf) n_ovf++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_x = out_tdata[47:0];
      got_y = out_tdata[95:48];
      n_out++;
      if (meet_expected.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected out beat x=%0d y=%0d user=%b",
                   $realtime, got_x, got_y, out_tuser);
      end else begin
        e = meet_expected.pop_front();
        if (got_x !== e.x || got_y !== e.y || out_tuser[0] !== e.par ||
            out_tuser[1] !== e.ovf) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: beat %0d mismatch: exp x=%0d y=%0d par=%b ovf=%b,",
                     $realtime, n_out, e.x, e.y, e.par, e.ovf,
                     " got x=%0d y=%0d par=%b ovf=%b",
                     got_x, got_y, out_tuser[0], out_tuser[1]);
        end
      end
    end
    // watchdog: no beat on either side for too long
    if (!rst_n || in_taken || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, meet_expected.size());
      $display("FAIL line_intersection_point_unit");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  function automatic int rnd_coord(input int mode);
    case (mode)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 128) - 64;
      default: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return 0;
          default: return $urandom_range(0, 65535) - 32768;
        endcase
      end
    endcase
  endfunction

  task automatic queue_random();
    int c[8];
    int mode, k, span;
    mode = $urandom_range(0, 9);
    span = (mode < 4) ? 0 : (mode < 7) ? 1 : 2;
    foreach (c[i]) c[i] = rnd_coord(span);
    case (mode)
      7: begin
        // B direction is a multiple of A direction (unless clamped): parallel
        k = $urandom_range(0, 4) - 2;
        c[0] = $urandom_range(0, 2000) - 1000;  c[1] = $urandom_range(0, 2000) - 1000;
        c[2] = c[0] + $urandom_range(0, 200) - 100;
        c[3] = c[1] + $urandom_range(0, 200) - 100;
        c[6] = c[4] + k * (c[2] - c[0]);
        c[7] = c[5] + k * (c[3] - c[1]);
        c[6] = (c[6] > 32767) ? 32767 : (c[6] < -32768) ? -32768 : c[6];
        c[7] = (c[7] > 32767) ? 32767 : (c[7] < -32768) ? -32768 : c[7];
      end
      8: begin
        // nearly parallel long lines: huge quotients, saturation
        c[6] = c[4] + (c[2] - c[0]) + $urandom_range(0, 2) - 1;
        c[7] = c[5] + (c[3] - c[1]) + $urandom_range(0, 2) - 1;
      end
      9: begin
        // degenerate: a line collapsed to a point
        if ($urandom_range(0, 1)) begin c[2] = c[0]; c[3] = c[1]; end
        else begin c[6] = c[4]; c[7] = c[5]; end
      end
      default: ;
    endcase
    queue_pts(pack_pts(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: simple crossings, signs, parallel, coincident, extremes
    queue_pts(pack_pts(0, 0, 0, 0, 0, 0, 0, 0));                       // all zero
    queue_pts(pack_pts(0, 0, 2, 2, 0, 2, 2, 0));                       // meet at (1,1)
    queue_pts(pack_pts(0, 0, 3, 0, 1, -5, 1, 7));                      // axis aligned
    queue_pts(pack_pts(0, 0, 1, 3, 0, 1, 3, 0));                       // fractional result
    queue_pts(pack_pts(-7, 3, 5, -2, 4, 4, -3, -6));                   // negative quotient
    queue_pts(pack_pts(0, 0, 1, 1, 0, 1, 1, 2));                       // parallel
    queue_pts(pack_pts(0, 0, 1, 1, 2, 2, 5, 5));                       // coincident
    queue_pts(pack_pts(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    queue_pts(pack_pts(-32768, -32768, 32767, 32767, -32768, -32767, 32767, 32767));
    queue_pts(pack_pts(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32767));
    queue_pts(pack_pts(-32768, 32767, -32767, -32768, 32767, -32768, 32766, 32767));
    queue_pts(pack_pts(32767, -32768, -32768, 32767, 32767, -32767, -32768, 32766));
    queue_pts(pack_pts(-32768, 0, 32767, 1, -32768, 1, 32767, 1));    // nearly parallel
    queue_pts(pack_pts(32767, 32767, 32767, 32767, 0, 0, 1, 1));      // A is a point
    queue_pts(pack_pts(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    queue_pts(pack_pts(-1, -1, 1, 1, -1, 1, 1, -1));
    queue_pts(pack_pts(12345, -23456, -31000, 30001, 1, 32767, -1, -32768));

    // sender pause: let every directed result come back before going random
    wait (n_in == n_queued && meet_expected.size() == 0);

    // random part; the receiver holds off for a long stretch early on
    rx_hold_req = 1;
    repeat (1500) queue_random();
    wait (pend_pts.size() < 100);
    no_idle = 1;                       // tail of the run at full rate
    repeat (300) queue_random();

    wait (n_in == n_queued && meet_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d line pairs: %0d parallel, %0d saturated, full-range, small and",
             n_in, n_par, n_ovf);
    $display("near-parallel sets under random stalls and a %0d-cycle output hold-off",
             RX_HOLD_CYCLES);
    if (n_mismatch == 0 && meet_expected.size() == 0) begin
      $display("PASS line_intersection_point_unit");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, meet_expected.size());
      $display("FAIL line_intersection_point_unit");
    end
    $finish;
  end
endmodule
